// ===== design/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg: shared types and constants of the seekable ChaCha20 keystream
// Item format, status and register codes, and the quarter-round half step.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_SEEK_START = 2'd1;
    localparam logic [1:0] KIND_SEEK_REL   = 2'd2;
    localparam logic [1:0] KIND_SEEK_END   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_PAST   = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_KEY_FULL = 3'd4;
    localparam logic [2:0] REG_NONCE_LO = 3'd5;
    localparam logic [2:0] REG_NONCE_HI = 3'd6;
    localparam logic [2:0] REG_NCODE    = 3'd7;

    localparam logic [1:0] NCODE_8  = 2'd0;
    localparam logic [1:0] NCODE_12 = 2'd1;

    localparam logic [63:0] STREAM_TOP = 64'h8000_0000_0000_0000;
    localparam logic [6:0]  BLOCK_BYTES = 7'd64;

    localparam logic [31:0] CONST_W0      = 32'h6170_7865;
    localparam logic [31:0] CONST_W1_FULL = 32'h3320_646e;
    localparam logic [31:0] CONST_W1_HALF = 32'h3120_646e;
    localparam logic [31:0] CONST_W2_FULL = 32'h7962_2d32;
    localparam logic [31:0] CONST_W2_HALF = 32'h7962_2d36;
    localparam logic [31:0] CONST_W3      = 32'h6b20_6574;

    typedef logic [3:0][31:0]  words4_t;
    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_in;
        logic [63:0] offset;
        logic        neg;
        logic [63:0] mag;
    } item_t;

    typedef struct packed {
        logic start;
    } core_req_t;

    typedef struct packed {
        logic done;
    } core_rsp_t;

    // Counter value held in words 12 and 13 for a given nonce layout.
    function automatic logic [63:0] init_ctr(logic [1:0] code, logic [63:0] nonce_lo);
        logic [63:0] r;
        begin
            case (code)
                NCODE_8:  r = 64'd0;
                NCODE_12: r = {nonce_lo[31:0], 32'd0};
                default:  r = nonce_lo;
            endcase
            return r;
        end
    endfunction

    // Half of a quarter round: the first two or the last two add/xor/rotate steps.
    // Element order is a, b, c, d at indexes 0 to 3.
    function automatic words4_t qr_half(words4_t v, logic second);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        words4_t     r;
        begin
            a = v[0] + v[1];
            d = v[3] ^ a;
            d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
            c = v[2] + d;
            b = v[1] ^ c;
            b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
            r[0] = a;
            r[1] = b;
            r[2] = c;
            r[3] = d;
            return r;
        end
    endfunction

endpackage

// ===== design/cc20_front.sv =====
// ----------------------------------------------------------------------------
// cc20_front: input side of the keystream block
// Accepts words, splits the seek offset into sign and magnitude and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cc20_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [7:0]        s_data_in,
    input  logic signed [63:0] s_offset,
    output logic              q_valid,
    output cc20_pkg::item_t   q_item,
    input  logic              q_pop
);

    cc20_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    cc20_pkg::item_t new_item;
    logic            push;
    logic            pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        new_item.kind    = s_kind;
        new_item.data_in = s_data_in;
        new_item.offset  = s_offset;
        new_item.neg     = s_offset[63];
        new_item.mag     = s_offset[63] ? (~s_offset + 64'd1) : s_offset;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== design/cc20_core.sv =====
// ----------------------------------------------------------------------------
// cc20_core: ChaCha block function
// Four quarter-round lanes, each doing half a quarter round per cycle,
// column and diagonal rounds by turns, then the final feed-forward add.
// ----------------------------------------------------------------------------
module cc20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cc20_pkg::core_req_t req,
    input  cc20_pkg::block_t    init_words,
    output cc20_pkg::core_rsp_t rsp,
    output cc20_pkg::block_t    ks_words
);

    localparam int RW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
    localparam logic [RW-1:0] RND_LAST = RW'(DOUBLE_ROUNDS - 1);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_ADD  = 3'b100
    } core_state_t;

    core_state_t      state_reg;
    core_state_t      state_next;
    cc20_pkg::block_t w_reg;
    cc20_pkg::block_t w_next;
    cc20_pkg::block_t ks_reg;
    logic [RW-1:0]    rnd_reg;
    logic             diag_reg;
    logic             half_reg;
    logic             done_reg;
    logic             last_step;

    assign ks_words  = ks_reg;
    assign rsp.done  = done_reg;
    assign last_step = half_reg && diag_reg && (rnd_reg == RND_LAST);

    always_comb begin
        int               ib;
        int               ic;
        int               id;
        cc20_pkg::words4_t lane_in;
        cc20_pkg::words4_t lane_out;
        w_next = w_reg;
        for (int j = 0; j < 4; j++) begin
            ib = diag_reg ? 4 + ((j + 1) % 4) : 4 + j;
            ic = diag_reg ? 8 + ((j + 2) % 4) : 8 + j;
            id = diag_reg ? 12 + ((j + 3) % 4) : 12 + j;
            lane_in[0] = w_reg[j];
            lane_in[1] = w_reg[ib[3:0]];
            lane_in[2] = w_reg[ic[3:0]];
            lane_in[3] = w_reg[id[3:0]];
            lane_out = cc20_pkg::qr_half(lane_in, half_reg);
            w_next[j]      = lane_out[0];
            w_next[ib[3:0]] = lane_out[1];
            w_next[ic[3:0]] = lane_out[2];
            w_next[id[3:0]] = lane_out[3];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (req.start) state_next = C_RUN;
            C_RUN:   if (last_step) state_next = C_ADD;
            C_ADD:   state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            diag_reg  <= 1'b0;
            half_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_ADD);
            if (state_reg == C_RUN) begin
                half_reg <= ~half_reg;
                if (half_reg) begin
                    diag_reg <= ~diag_reg;
                    if (diag_reg) begin
                        rnd_reg <= last_step ? '0 : rnd_reg + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: if (req.start) w_reg <= init_words;
            C_RUN:  w_reg <= w_next;
            C_ADD: begin
                for (int i = 0; i < 16; i++) begin
                    ks_reg[i] <= w_reg[i] + init_words[i];
                end
            end
            default: w_reg <= w_reg;
        endcase
    end

endmodule

// ===== design/cc20_back.sv =====
// ----------------------------------------------------------------------------
// cc20_back: execution side of the keystream block
// Holds the configuration and stream state, runs data and seek words,
// drives the block function and the result register.
// ----------------------------------------------------------------------------
module cc20_back #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic            q_valid,
    input  cc20_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_data_out,
    output logic [1:0]      m_status,
    output logic [63:0]     m_position
);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_EXEC  = 6'b000010,
        B_PLACE = 6'b000100,
        B_LOAD  = 6'b001000,
        B_WAIT  = 6'b010000,
        B_RESP  = 6'b100000
    } back_state_t;

    back_state_t         state_reg;
    cc20_pkg::item_t     item_reg;
    logic [63:0]         key_reg [4];
    logic                key_full_reg;
    logic [63:0]         nonce_lo_reg;
    logic [63:0]         nonce_hi_reg;
    logic [1:0]          ncode_reg;
    logic [63:0]         bc_reg;
    logic [63:0]         base_reg;
    logic [6:0]          rem_reg;
    logic [63:0]         pos_reg;
    logic [63:0]         ctr_reg;
    logic [63:0]         np_reg;
    logic [7:0]          res_data_reg;
    logic [1:0]          res_status_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [7:0]          m_data_reg;
    logic [1:0]          m_status_reg;
    logic [63:0]         m_position_reg;

    cc20_pkg::block_t    init_words;
    cc20_pkg::block_t    ks_words;
    cc20_pkg::core_req_t core_req;
    cc20_pkg::core_rsp_t core_rsp;

    logic [63:0]         k2;
    logic [63:0]         k3;
    logic [63:0]         nonce_lo_new;
    logic [1:0]          ncode_new;
    logic [63:0]         ctr_cfg;
    logic [5:0]          rd_idx;
    logic [31:0]         rd_word;
    logic [7:0]          ks_byte;
    logic [63:0]         seek_pos;
    logic [1:0]          seek_status;
    logic [63:0]         rel_sum;
    logic                out_free;
    logic                is_data;

    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_position_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign q_pop      = (state_reg == B_IDLE) && q_valid;
    assign is_data    = (item_reg.kind == cc20_pkg::KIND_DATA);
    assign core_req.start = (state_reg == B_LOAD);

    // Result valid: cleared when taken, set when a new result is loaded.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if ((state_reg == B_RESP) && out_free) m_valid_next = 1'b1;
    end

    // Block function input words.
    always_comb begin
        k2 = key_full_reg ? key_reg[2] : key_reg[0];
        k3 = key_full_reg ? key_reg[3] : key_reg[1];
        init_words[0]  = cc20_pkg::CONST_W0;
        init_words[1]  = key_full_reg ? cc20_pkg::CONST_W1_FULL : cc20_pkg::CONST_W1_HALF;
        init_words[2]  = key_full_reg ? cc20_pkg::CONST_W2_FULL : cc20_pkg::CONST_W2_HALF;
        init_words[3]  = cc20_pkg::CONST_W3;
        init_words[4]  = key_reg[0][31:0];
        init_words[5]  = key_reg[0][63:32];
        init_words[6]  = key_reg[1][31:0];
        init_words[7]  = key_reg[1][63:32];
        init_words[8]  = k2[31:0];
        init_words[9]  = k2[63:32];
        init_words[10] = k3[31:0];
        init_words[11] = k3[63:32];
        init_words[12] = ctr_reg[31:0];
        init_words[13] = ctr_reg[63:32];
        case (ncode_reg)
            cc20_pkg::NCODE_8: begin
                init_words[14] = nonce_lo_reg[31:0];
                init_words[15] = nonce_lo_reg[63:32];
            end
            cc20_pkg::NCODE_12: begin
                init_words[14] = nonce_lo_reg[63:32];
                init_words[15] = nonce_hi_reg[31:0];
            end
            default: begin
                init_words[14] = nonce_hi_reg[31:0];
                init_words[15] = nonce_hi_reg[63:32];
            end
        endcase
    end

    // Counter value that a configuration write loads.
    always_comb begin
        nonce_lo_new = (cfg_index == cc20_pkg::REG_NONCE_LO) ? cfg_data : nonce_lo_reg;
        ncode_new    = (cfg_index == cc20_pkg::REG_NCODE) ? cfg_data[1:0] : ncode_reg;
        ctr_cfg      = cc20_pkg::init_ctr(ncode_new, nonce_lo_new);
    end

    // Keystream byte at the current position within the block.
    always_comb begin
        logic [6:0] used;
        used    = cc20_pkg::BLOCK_BYTES - rem_reg;
        rd_idx  = used[5:0];
        rd_word = ks_words[rd_idx[5:2]];
        ks_byte = rd_word[{rd_idx[1:0], 3'b000} +: 8];
    end

    // New position and range check of a seek.
    always_comb begin
        rel_sum     = pos_reg + item_reg.offset;
        seek_pos    = item_reg.offset;
        seek_status = cc20_pkg::ST_OK;
        case (item_reg.kind)
            cc20_pkg::KIND_SEEK_START: begin
                if (item_reg.neg) seek_status = cc20_pkg::ST_BEFORE;
            end
            cc20_pkg::KIND_SEEK_REL: begin
                seek_pos = rel_sum;
                if (item_reg.neg) begin
                    if (pos_reg < item_reg.mag) seek_status = cc20_pkg::ST_BEFORE;
                end else if (rel_sum[63]) begin
                    seek_status = cc20_pkg::ST_PAST;
                end
            end
            cc20_pkg::KIND_SEEK_END: begin
                seek_pos = cc20_pkg::STREAM_TOP + item_reg.offset;
                if (!item_reg.neg) seek_status = cc20_pkg::ST_PAST;
            end
            default: seek_status = cc20_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            key_reg[0]   <= 64'd0;
            key_reg[1]   <= 64'd0;
            key_reg[2]   <= 64'd0;
            key_reg[3]   <= 64'd0;
            key_full_reg <= 1'b1;
            nonce_lo_reg <= 64'd0;
            nonce_hi_reg <= 64'd0;
            ncode_reg    <= cc20_pkg::NCODE_8;
            bc_reg       <= 64'd0;
            base_reg     <= 64'd0;
            rem_reg      <= 7'd0;
            pos_reg      <= 64'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) state_reg <= B_EXEC;
                end
                B_EXEC: begin
                    if (is_data) begin
                        if (rem_reg == 7'd0) begin
                            if (bc_reg[63]) begin
                                state_reg <= B_RESP;
                            end else begin
                                state_reg <= B_LOAD;
                            end
                        end else begin
                            rem_reg   <= rem_reg - 7'd1;
                            pos_reg   <= pos_reg + 64'd1;
                            state_reg <= B_RESP;
                        end
                    end else if (seek_status != cc20_pkg::ST_OK) begin
                        state_reg <= B_RESP;
                    end else begin
                        state_reg <= B_PLACE;
                    end
                end
                B_PLACE: begin
                    rem_reg   <= cc20_pkg::BLOCK_BYTES - {1'b0, np_reg[5:0]};
                    pos_reg   <= np_reg;
                    state_reg <= B_LOAD;
                end
                B_LOAD: begin
                    bc_reg <= ctr_reg + 64'd1;
                    if (is_data) rem_reg <= cc20_pkg::BLOCK_BYTES;
                    state_reg <= B_WAIT;
                end
                B_WAIT: begin
                    if (core_rsp.done) begin
                        state_reg <= is_data ? B_EXEC : B_RESP;
                    end
                end
                B_RESP: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
            if (cfg_valid) begin
                case (cfg_index)
                    cc20_pkg::REG_KEY0:     key_reg[0]   <= cfg_data;
                    cc20_pkg::REG_KEY1:     key_reg[1]   <= cfg_data;
                    cc20_pkg::REG_KEY2:     key_reg[2]   <= cfg_data;
                    cc20_pkg::REG_KEY3:     key_reg[3]   <= cfg_data;
                    cc20_pkg::REG_KEY_FULL: key_full_reg <= cfg_data[0];
                    cc20_pkg::REG_NONCE_LO: nonce_lo_reg <= cfg_data;
                    cc20_pkg::REG_NONCE_HI: nonce_hi_reg <= cfg_data;
                    cc20_pkg::REG_NCODE:    ncode_reg    <= cfg_data[1:0];
                    default:                ncode_reg    <= ncode_reg;
                endcase
                bc_reg   <= ctr_cfg;
                base_reg <= ctr_cfg;
                rem_reg  <= 7'd0;
                pos_reg  <= 64'd0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (q_pop) item_reg <= q_item;
        case (state_reg)
            B_EXEC: begin
                if (is_data) begin
                    if (rem_reg == 7'd0) begin
                        ctr_reg        <= bc_reg;
                        res_data_reg   <= 8'd0;
                        res_status_reg <= cc20_pkg::ST_OVF;
                    end else begin
                        res_data_reg   <= item_reg.data_in ^ ks_byte;
                        res_status_reg <= cc20_pkg::ST_OK;
                    end
                end else begin
                    np_reg         <= seek_pos;
                    res_data_reg   <= 8'd0;
                    res_status_reg <= seek_status;
                end
            end
            B_PLACE: ctr_reg <= base_reg + {6'd0, np_reg[63:6]};
            B_RESP: begin
                if (out_free) begin
                    m_data_reg     <= res_data_reg;
                    m_status_reg   <= res_status_reg;
                    m_position_reg <= pos_reg;
                end
            end
            default: ctr_reg <= ctr_reg;
        endcase
    end

    cc20_core #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (core_req),
        .init_words(init_words),
        .rsp       (core_rsp),
        .ks_words  (ks_words)
    );

endmodule

// ===== design/chacha20_seekable_keystream.sv =====
// ----------------------------------------------------------------------------
// chacha20_seekable_keystream: seekable ChaCha20 byte stream cipher
// Top level joining the input queue, the execution side and the block function.
// ----------------------------------------------------------------------------
// Each input word is either a data byte, which is XORed with the next
// keystream byte, or a seek (from the start, relative to the current position,
// or back from the end of the 2^63-byte stream), and each gives exactly one
// result word carrying the output byte, a status code and the new byte
// position. Words are handled one at a time by the execution side. A data byte
// inside the current block passes from idle through execute to the response
// state. When the block is used up, or after a valid seek, the block function
// loads the words and makes a new 64-byte block with four quarter-round lanes
// that each do half a quarter round per cycle, by column and diagonal rounds
// in turn, then does the final add and hands the block over. A two-entry queue
// in front lets new words arrive while a block is being made, and the result
// register lets the next word start while a result still waits to be taken.
// Configuration writes are taken in any cycle but must only be given while
// the block is idle; every write reloads the counter from the nonce layout,
// sets the position to zero and empties the keystream. After reset the key
// is zero, a full key is selected and the nonce is eight zero bytes.
// ----------------------------------------------------------------------------
module chacha20_seekable_keystream #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [7:0]         s_data_in,
    input  logic signed [63:0] s_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_data_out,
    output logic [1:0]         m_status,
    output logic [63:0]        m_position,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    // Queue between the input side and the execution side.
    logic            q_valid;
    logic            q_pop;
    cc20_pkg::item_t q_item;

    // Registers are always writable; the user must give writes only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    cc20_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_data_in(s_data_in),
        .s_offset (s_offset),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    cc20_back #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data_out(m_data_out),
        .m_status  (m_status),
        .m_position(m_position)
    );

endmodule

// ===== design/cc20_checker.sv =====
// ----------------------------------------------------------------------------
// cc20_checker: port-level checks of the keystream block
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module cc20_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_data_out,
    input logic [1:0]  m_status,
    input logic [63:0] m_position
);

    // A stalled result word keeps its position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position))
        else $error("result word changed while stalled");

    // No result word may appear right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // Error results carry a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != cc20_pkg::ST_OK) |-> (m_data_out == 8'd0))
        else $error("nonzero byte on an error result");

    // A stalled result word keeps its byte and status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data_out) && $stable(m_status))
        else $error("result byte or status changed while stalled");

endmodule

bind chacha20_seekable_keystream cc20_checker u_cc20_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data_out(m_data_out),
    .m_status  (m_status),
    .m_position(m_position)
);

// ===== bench/tb_chacha20_seekable_keystream.sv =====
// ----------------------------------------------------------------------------
// tb_chacha20_seekable_keystream: self-checking bench of the keystream cipher
// Drives data bytes and seeks with random gaps, predicts every result word
// with an independent ChaCha20 block function, and compares in order.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the cipher state and a queue of the
// result words that the block owes.
class cipher_scoreboard;
    logic [63:0] key_lo_a, key_lo_b, key_hi_a, key_hi_b;
    logic        full_key;
    logic [63:0] nonce_lo, nonce_hi;
    logic [1:0]  ncode;
    logic [31:0] fixed_w [16];
    logic [63:0] blk_ctr, base_ctr;
    logic [7:0]  ks [64];
    int unsigned left;
    logic [7:0]  exp_byte [$];
    logic [1:0]  exp_status [$];
    logic [63:0] exp_pos [$];
    int          mismatches;

    function new();
        key_lo_a = 0; key_lo_b = 0; key_hi_a = 0; key_hi_b = 0;
        full_key = 1; nonce_lo = 0; nonce_hi = 0; ncode = 0;
        mismatches = 0;
        reload();
    endfunction

    function logic [31:0] rol(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function void quarter(ref logic [31:0] w [16], input int a, int b, int c, int d);
        w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
    endfunction

    // Rebuild the fixed words and restart at the nonce's own counter.
    function void reload();
        logic [63:0] k2, k3;
        k2 = full_key ? key_hi_a : key_lo_a;
        k3 = full_key ? key_hi_b : key_lo_b;
        fixed_w[0] = cc20_pkg::CONST_W0;
        fixed_w[1] = full_key ? cc20_pkg::CONST_W1_FULL : cc20_pkg::CONST_W1_HALF;
        fixed_w[2] = full_key ? cc20_pkg::CONST_W2_FULL : cc20_pkg::CONST_W2_HALF;
        fixed_w[3] = cc20_pkg::CONST_W3;
        fixed_w[4] = key_lo_a[31:0]; fixed_w[5] = key_lo_a[63:32];
        fixed_w[6] = key_lo_b[31:0]; fixed_w[7] = key_lo_b[63:32];
        fixed_w[8] = k2[31:0];  fixed_w[9] = k2[63:32];
        fixed_w[10] = k3[31:0]; fixed_w[11] = k3[63:32];
        if (ncode == cc20_pkg::NCODE_8) begin
            fixed_w[12] = 0; fixed_w[13] = 0;
            fixed_w[14] = nonce_lo[31:0]; fixed_w[15] = nonce_lo[63:32];
        end else if (ncode == cc20_pkg::NCODE_12) begin
            fixed_w[12] = 0; fixed_w[13] = nonce_lo[31:0];
            fixed_w[14] = nonce_lo[63:32]; fixed_w[15] = nonce_hi[31:0];
        end else begin
            fixed_w[12] = nonce_lo[31:0]; fixed_w[13] = nonce_lo[63:32];
            fixed_w[14] = nonce_hi[31:0]; fixed_w[15] = nonce_hi[63:32];
        end
        blk_ctr = {fixed_w[13], fixed_w[12]};
        base_ctr = blk_ctr;
        left = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            cc20_pkg::REG_KEY0:     key_lo_a = val;
            cc20_pkg::REG_KEY1:     key_lo_b = val;
            cc20_pkg::REG_KEY2:     key_hi_a = val;
            cc20_pkg::REG_KEY3:     key_hi_b = val;
            cc20_pkg::REG_KEY_FULL: full_key = val[0];
            cc20_pkg::REG_NONCE_LO: nonce_lo = val;
            cc20_pkg::REG_NONCE_HI: nonce_hi = val;
            default:                ncode = val[1:0];
        endcase
        reload();
    endfunction

    function void make_keystream(logic [63:0] ctr);
        logic [31:0] w [16];
        logic [31:0] v;
        for (int i = 0; i < 16; i++) w[i] = fixed_w[i];
        w[12] = ctr[31:0]; w[13] = ctr[63:32];
        for (int r = 0; r < 10; r++) begin
            quarter(w, 0, 4, 8, 12); quarter(w, 1, 5, 9, 13);
            quarter(w, 2, 6, 10, 14); quarter(w, 3, 7, 11, 15);
            quarter(w, 0, 5, 10, 15); quarter(w, 1, 6, 11, 12);
            quarter(w, 2, 7, 8, 13); quarter(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            v = w[i] + fixed_w[i] + ((i == 12) ? ctr[31:0] - fixed_w[12] : 0)
                + ((i == 13) ? ctr[63:32] - fixed_w[13] : 0);
            for (int b = 0; b < 4; b++) ks[4 * i + b] = v[8 * b +: 8];
        end
    endfunction

    function logic [63:0] where_now();
        return (blk_ctr - base_ctr) * 64 - 64'(left);
    endfunction

    // Note an accepted input word and queue the result that it owes.
    function void note_word(logic [1:0] kind, logic [7:0] din, logic [63:0] off);
        logic        neg;
        logic [63:0] mag, old, np;
        logic [1:0]  st;
        logic [7:0]  dout;
        neg = off[63];
        mag = neg ? -off : off;
        old = where_now();
        np = 0; st = cc20_pkg::ST_OK; dout = 0;
        if (kind == cc20_pkg::KIND_DATA) begin
            if (left == 0) begin
                if (blk_ctr[63]) st = cc20_pkg::ST_OVF;
                else begin
                    make_keystream(blk_ctr);
                    blk_ctr += 1;
                    left = 64;
                end
            end
            if (st == cc20_pkg::ST_OK) begin
                dout = din ^ ks[(64 - left) & 63];
                left -= 1;
            end
        end else begin
            if (kind == cc20_pkg::KIND_SEEK_START) begin
                if (neg) st = cc20_pkg::ST_BEFORE; else np = mag;
            end else if (kind == cc20_pkg::KIND_SEEK_REL) begin
                if (neg) begin
                    if (mag > old) st = cc20_pkg::ST_BEFORE; else np = old - mag;
                end else begin
                    np = old + mag;
                    if (np[63]) st = cc20_pkg::ST_PAST;
                end
            end else begin
                if (!neg) st = cc20_pkg::ST_PAST; else np = cc20_pkg::STREAM_TOP - mag;
            end
            if (st == cc20_pkg::ST_OK) begin
                make_keystream(base_ctr + (np >> 6));
                blk_ctr = base_ctr + (np >> 6) + 1;
                left = 64 - int'(np[5:0]);
            end
        end
        exp_byte.push_back(dout);
        exp_status.push_back(st);
        exp_pos.push_back(where_now());
    endfunction

    // Check one accepted result word against the oldest expectation.
    function void check_word(logic [7:0] dout, logic [1:0] st, logic [63:0] pos);
        logic [7:0]  eb;
        logic [1:0]  es;
        logic [63:0] ep;
        if (exp_byte.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %h %0d %h", dout, st, pos);
            return;
        end
        eb = exp_byte.pop_front();
        es = exp_status.pop_front();
        ep = exp_pos.pop_front();
        if (eb !== dout || es !== st || ep !== pos) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected %h/%0d/%h, got %h/%0d/%h",
                         eb, es, ep, dout, st, pos);
        end
    endfunction
endclass

module tb_chacha20_seekable_keystream;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_kind = 0;
    logic [7:0]  s_data_in = 0;
    logic [63:0] s_offset = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [7:0]  m_data_out;
    logic [1:0]  m_status;
    logic [63:0] m_position;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [63:0] cfg_data = 0;

    cipher_scoreboard cipher = new();
    // Receiver modes: 0 random stalls, 1 always ready, 2 long hold-off.
    int sink_mode = 0;

    chacha20_seekable_keystream dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_data_in(s_data_in), .s_offset(s_offset),
        .m_valid(m_valid), .m_ready(m_ready), .m_data_out(m_data_out),
        .m_status(m_status), .m_position(m_position),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Generous ceiling: every word here may need a new block, plus long
    // stalls on both sides.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: samples at the clock edge, checks on each handshake.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            cipher.check_word(m_data_out, m_status, m_position);
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (sink_mode == 2) begin
                // Long hold-off counted here while the sender keeps offering.
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                sink_mode = 0;
            end else if (sink_mode == 1) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                hold = pick_gap();
                m_ready <= (hold == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    // Offer one word and hold it until the block takes it. Valid stays up
    // after the handshake so that a following word can go out back to back.
    task automatic send_word(logic [1:0] kind, logic [7:0] din, logic [63:0] off,
                             bit no_gap = 0);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_data_in <= din;
        s_offset <= off;
        do @(posedge aclk); while (!s_ready);
        cipher.note_word(kind, din, off);
    endtask

    // Waits until every owed result has come, then lets a block build finish.
    task automatic drain();
        s_valid <= 1'b0;
        while (cipher.exp_byte.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cipher.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // A random offset: mostly small in magnitude, sometimes anywhere.
    function automatic logic [63:0] rand_offset(logic [1:0] kind);
        int          r;
        logic [63:0] m;
        r = $urandom_range(0, 9);
        m = 64'($urandom_range(0, 300));
        if (r < 5) begin
            if (kind == cc20_pkg::KIND_SEEK_START || $urandom_range(0, 1) == 1) return m;
            return -m;
        end
        if (r < 7) return -64'($urandom_range(1, 300));
        return rand64();
    endfunction

    task automatic random_config();
        write_reg(cc20_pkg::REG_KEY0, rand64());
        write_reg(cc20_pkg::REG_KEY1, rand64());
        write_reg(cc20_pkg::REG_KEY2, rand64());
        write_reg(cc20_pkg::REG_KEY3, rand64());
        write_reg(cc20_pkg::REG_KEY_FULL, 64'($urandom_range(0, 1)));
        write_reg(cc20_pkg::REG_NONCE_LO, rand64());
        write_reg(cc20_pkg::REG_NONCE_HI, rand64());
        write_reg(cc20_pkg::REG_NCODE, 64'($urandom_range(0, 3)));
    endtask

    initial begin
        logic [1:0] k;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: every kind, edge bytes and the
        // error cases of each seek.
        send_word(cc20_pkg::KIND_DATA, 8'h00, 64'd0);
        send_word(cc20_pkg::KIND_DATA, 8'hff, 64'd0);
        send_word(cc20_pkg::KIND_SEEK_START, 8'h00, -64'd1);
        send_word(cc20_pkg::KIND_SEEK_START, 8'h00, 64'd130);
        send_word(cc20_pkg::KIND_DATA, 8'h5a, 64'd0);
        send_word(cc20_pkg::KIND_SEEK_REL, 8'h00, -64'd1000);
        send_word(cc20_pkg::KIND_SEEK_REL, 8'h00, 64'h7fff_ffff_ffff_ffff);
        send_word(cc20_pkg::KIND_SEEK_REL, 8'h00, -64'd2);
        send_word(cc20_pkg::KIND_SEEK_END, 8'h00, 64'd0);
        send_word(cc20_pkg::KIND_SEEK_END, 8'h00, 64'h8000_0000_0000_0000);
        send_word(cc20_pkg::KIND_DATA, 8'ha5, 64'd0);
        send_word(cc20_pkg::KIND_SEEK_END, 8'h00, -64'd1);
        send_word(cc20_pkg::KIND_DATA, 8'h11, 64'd0);
        drain();

        // Nonce in the counter words with bit 63 set: the stream start is
        // already past the counter limit, so the first new block overflows.
        write_reg(cc20_pkg::REG_NCODE, 64'd3);
        write_reg(cc20_pkg::REG_NONCE_LO, 64'h8000_0000_0000_0005);
        send_word(cc20_pkg::KIND_DATA, 8'h77, 64'd0);
        send_word(cc20_pkg::KIND_SEEK_START, 8'h00, 64'd3);
        send_word(cc20_pkg::KIND_DATA, 8'h77, 64'd0);
        send_word(cc20_pkg::KIND_SEEK_START, 8'h00, 64'd63);
        send_word(cc20_pkg::KIND_DATA, 8'h01, 64'd0);
        send_word(cc20_pkg::KIND_DATA, 8'h02, 64'd0);
        drain();
        write_reg(cc20_pkg::REG_KEY_FULL, 64'd0);
        write_reg(cc20_pkg::REG_KEY0, '1);
        write_reg(cc20_pkg::REG_NCODE, 64'd1);
        write_reg(cc20_pkg::REG_NONCE_LO, '1);
        write_reg(cc20_pkg::REG_NONCE_HI, '1);
        send_word(cc20_pkg::KIND_DATA, 8'h80, 64'd0);
        drain();

        // Receiver holds off while words keep coming.
        sink_mode = 2;
        for (int i = 0; i < 20; i++)
            send_word(cc20_pkg::KIND_DATA, 8'($urandom()), 64'd0, 1);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            random_config();
            sink_mode = (phase == 3) ? 1 : 0;
            for (int i = 0; i < 150; i++) begin
                k = ($urandom_range(0, 9) < 7) ? cc20_pkg::KIND_DATA :
                    2'($urandom_range(1, 3));
                send_word(k, 8'($urandom()),
                          k == cc20_pkg::KIND_DATA ? rand64() : rand_offset(k));
            end
            // Sender pause until every owed result has arrived.
            drain();
        end

        if (cipher.mismatches == 0 && cipher.exp_byte.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/cc20_pkg.sv
design/cc20_front.sv
design/cc20_core.sv
design/cc20_back.sv
design/chacha20_seekable_keystream.sv
design/cc20_checker.sv
bench/tb_chacha20_seekable_keystream.sv
